>>> src/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// Check an implication that includes reset cycles.
`define ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("assertion failed");
`endif

>>> src/ppp_pkg.sv
// Package with types and constants of the perspective point projector.
package ppp_pkg;
  localparam int unsigned CoefFracBitsDefault = 16;
  localparam int unsigned QueueDepth = 2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_VOFF   = 2'd2;
  localparam logic [1:0] REG_DEPTH  = 2'd3;

  localparam logic [12:0] ResetWidth  = 13'd1024;
  localparam logic [12:0] ResetHeight = 13'd768;
  localparam logic [7:0]  ResetVoff   = 8'd30;
  localparam logic [16:0] ResetDepth  = 17'd655;

  typedef struct packed {
    logic               op;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } in_item_t;

  typedef struct packed {
    logic               is_projection;
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
  } out_item_t;

  // Queue entry from the front to the back part.
  typedef struct packed {
    logic               project;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } job_t;
endpackage

>>> src/ppp_front.sv
// Front part: accepts items, holds the matrix and queues items for the back part.
module ppp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ppp_pkg::in_item_t  item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               avail_o,
  output ppp_pkg::job_t      job_o,
  input  logic [3:0]         rd_idx_i,
  output logic signed [31:0] coef_o
);
  localparam int unsigned QW = $clog2(ppp_pkg::QueueDepth);

  logic signed [31:0] mat_q [16];
  ppp_pkg::job_t      queue_q [ppp_pkg::QueueDepth];
  logic [QW-1:0]      wr_q, rd_q;
  logic [QW:0]        cnt_q;

  assign full_o  = (cnt_q == (QW+1)'(ppp_pkg::QueueDepth));
  assign avail_o = (cnt_q != '0);
  assign job_o   = queue_q[rd_q];
  assign coef_o  = mat_q[rd_idx_i];

  // Matrix store; a load writes its coefficient when the back part takes it, so
  // points queued ahead of it still see the old matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else if (pop_i && !job_o.project) begin
      mat_q[job_o.coef_index] <= job_o.coef_value;
    end
  end

  // Queue payload.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      queue_q[wr_q] <= '{project: item_i.op == ppp_pkg::OP_PROJECT,
                         coef_index: item_i.coef_index, coef_value: item_i.coef_value,
                         world_x: item_i.world_x, world_y: item_i.world_y,
                         world_z: item_i.world_z};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (accept_i) wr_q <= (wr_q == QW'(ppp_pkg::QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (pop_i) rd_q <= (rd_q == QW'(ppp_pkg::QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (QW+1)'(accept_i) - (QW+1)'(pop_i);
    end
  end
endmodule

>>> src/ppp_back.sv
// Back part: clip transform with a shared multiplier, serial divide, viewport map.
module ppp_back #(
  parameter int unsigned CoefFracBits = ppp_pkg::CoefFracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               avail_i,
  input  ppp_pkg::job_t      job_i,
  output logic               pop_o,
  output logic [3:0]         rd_idx_o,
  input  logic signed [31:0] coef_i,
  input  logic [12:0]        width_i,
  input  logic [12:0]        height_i,
  input  logic [7:0]         voff_i,
  input  logic [16:0]        depth_i,
  output logic               valid_o,
  output ppp_pkg::out_item_t result_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_MAC = 3'd1, S_ACC = 3'd2,
                         S_NUM = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;
  localparam int unsigned DivBits = 66;

  logic [2:0]         state_q;
  ppp_pkg::job_t      job_q;
  logic [3:0]         idx_q;
  logic signed [63:0] prod_q;
  logic               prod_v_q;
  logic signed [65:0] acc_q, cx_q, cy_q, w_q;
  logic               axis_q;
  logic [DivBits-1:0] quo_q, rem_q;
  logic               neg_q;
  logic [6:0]         bit_q;
  logic signed [15:0] sx_q;
  logic               valid_q;
  ppp_pkg::out_item_t res_q;

  logic signed [32:0] opnd;
  logic signed [65:0] term;
  logic signed [65:0] num;
  logic [DivBits-1:0] wabs, rem_sh;
  logic signed [15:0] sat;

  assign rd_idx_o = idx_q;
  assign pop_o    = (state_q == S_IDLE) && avail_i;
  assign valid_o  = valid_q;
  assign result_o = res_q;

  // Operand for the current column; column 3 is the constant 1.
  always_comb begin
    unique case (idx_q[1:0])
      2'd0:    opnd = 33'(job_q.world_x);
      2'd1:    opnd = 33'(job_q.world_y);
      2'd2:    opnd = 33'(job_q.world_z);
      default: opnd = 33'sd1;
    endcase
  end

  // Scale the registered product to Q16.16 (floor for right shifts).
  always_comb begin
    if (idx_q[1:0] != 2'd0 || !prod_v_q) term = '0;
    else term = '0;
    if (prod_v_q) begin
      if (idx_q[1:0] == 2'd0) begin
        // product belongs to column 3 of the previous row
        if (CoefFracBits <= 16) term = 66'(prod_q) <<< (16 - CoefFracBits);
        else term = 66'(prod_q) >>> (CoefFracBits - 16);
      end else begin
        term = 66'(prod_q) >>> CoefFracBits;
      end
    end
  end

  // Numerator of the current axis.
  always_comb begin
    if (!axis_q) num = (66'(cx_q) + w_q) * $signed({1'b0, 12'(width_i >> 1)});
    else num = (w_q - cy_q) * $signed({1'b0, 12'(height_i >> 1)})
             + w_q * $signed({1'b0, voff_i});
  end

  assign wabs   = w_q;
  assign rem_sh = {rem_q[DivBits-2:0], quo_q[DivBits-1]};

  // Saturate the magnitude quotient with its sign.
  always_comb begin
    if (neg_q) sat = (quo_q > 66'd32768) ? -16'sd32768 : -$signed(16'(quo_q));
    else sat = (quo_q > 66'd32767) ? 16'sd32767 : $signed(16'(quo_q));
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_q <= 1'b0; prod_v_q <= 1'b0; idx_q <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          prod_v_q <= 1'b0;
          valid_q <= avail_i && !job_i.project;
          if (avail_i) begin
            job_q <= job_i; idx_q <= '0; acc_q <= '0;
            if (job_i.project) state_q <= S_MAC;
            else res_q <= '0;
          end
        end
        S_MAC: begin
          // one product per cycle, rows 0, 1, 3
          valid_q <= 1'b0;
          prod_q <= 64'(coef_i * opnd);
          prod_v_q <= 1'b1;
          if (prod_v_q) acc_q <= (idx_q[1:0] == 2'd1) ? term : acc_q + term;
          if (idx_q[1:0] == 2'd0 && prod_v_q) begin
            if (idx_q == 4'd4) cx_q <= acc_q + term;
            else cy_q <= acc_q + term;
          end
          idx_q <= (idx_q == 4'd7) ? 4'd12 : idx_q + 1'b1;
          if (idx_q == 4'd15) state_q <= S_ACC;
        end
        S_ACC: begin
          w_q <= acc_q + term; prod_v_q <= 1'b0; axis_q <= 1'b0;
          if ((acc_q + term) <= 0 || (acc_q + term) < $signed({49'd0, depth_i})) begin
            valid_q <= 1'b1; res_q <= '{1'b1, 1'b0, 16'sd0, 16'sd0};
            state_q <= S_IDLE;
          end else begin
            valid_q <= 1'b0; state_q <= S_NUM;
          end
        end
        S_NUM: begin
          valid_q <= 1'b0;
          neg_q <= num[65]; quo_q <= num[65] ? -num : num;
          rem_q <= '0; bit_q <= 7'(DivBits); state_q <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          valid_q <= 1'b0;
          if (rem_sh >= wabs) rem_q <= rem_sh - wabs;
          else rem_q <= rem_sh;
          quo_q <= {quo_q[DivBits-2:0], rem_sh >= wabs};
          bit_q <= bit_q - 1'b1;
          if (bit_q == 7'd1) state_q <= S_OUT;
        end
        default: begin
          valid_q <= axis_q;
          if (!axis_q) begin
            sx_q <= sat; axis_q <= 1'b1; state_q <= S_NUM;
          end else begin
            res_q <= '{1'b1, 1'b1, sx_q, sat};
            state_q <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

>>> src/perspective_point_projector.sv
// Top level of the perspective point projector.
// A load writes the matrix when the back part takes it from the queue. A point runs the
// multiply steps and is culled if w is not positive or is below the depth threshold;
// a visible point then takes, per axis, a setup step, a serial divide and a saturation step.
// The queue takes items while the back part works on a point; busy is high while it is full.
// Reset clears matrix and queue, loads config defaults; results strobe one cycle, no receiver stall.
`include "assert_macros.svh"
module perspective_point_projector #(
  parameter int unsigned CoefFracBits = ppp_pkg::CoefFracBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ppp_pkg::in_item_t  item_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [16:0]        cfg_data_i,
  output logic               done_o,
  output ppp_pkg::out_item_t result_o
);
  logic               accept, pop, avail;
  ppp_pkg::job_t      job;
  logic [3:0]         rd_idx;
  logic signed [31:0] coef;
  logic [12:0]        width_q, height_q;
  logic [7:0]         voff_q;
  logic [16:0]        depth_q;

  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= ppp_pkg::ResetWidth; height_q <= ppp_pkg::ResetHeight;
      voff_q <= ppp_pkg::ResetVoff; depth_q <= ppp_pkg::ResetDepth;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppp_pkg::REG_WIDTH:  width_q  <= cfg_data_i[12:0];
        ppp_pkg::REG_HEIGHT: height_q <= cfg_data_i[12:0];
        ppp_pkg::REG_VOFF:   voff_q   <= cfg_data_i[7:0];
        default:             depth_q  <= cfg_data_i;
      endcase
    end
  end

  ppp_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .item_i, .full_o(busy), .pop_i(pop),
    .avail_o(avail), .job_o(job), .rd_idx_i(rd_idx), .coef_o(coef)
  );

  ppp_back #(.CoefFracBits(CoefFracBits)) u_back (
    .clk_i, .rst_ni, .avail_i(avail), .job_i(job), .pop_o(pop), .rd_idx_o(rd_idx),
    .coef_i(coef), .width_i(width_q), .height_i(height_q), .voff_i(voff_q),
    .depth_i(depth_q), .valid_o(done_o), .result_o
  );

  `ASSERT_IMP(a_no_accept_full, clk_i, rst_ni, busy |-> !accept)
  `ASSERT_IMP(a_pop_avail, clk_i, rst_ni, pop |-> avail)
  `ASSERT_IMP(a_invis_zero, clk_i, rst_ni,
    (done_o && !result_o.visible) |-> (result_o.screen_x == 0 && result_o.screen_y == 0))
endmodule
